// ----- sv/ntcplt_pkg.sv -----
// Shared constants, table and codes for the NTC thermistor temperature converter.
package ntcplt_pkg;

    localparam int TABLE_ENTRIES  = 17;
    localparam int SAMPLE_BITS    = 12;
    localparam int STORED_ENTRIES = 17;
    localparam int SEARCH_LIMIT   = (TABLE_ENTRIES < STORED_ENTRIES) ?
                                    TABLE_ENTRIES : STORED_ENTRIES;
    localparam int IDX_W          = $clog2(STORED_ENTRIES);
    localparam int ENTRY_W        = 12;
    localparam int IN_W           = 12;
    localparam int IN_BYTES_W     = 16;
    localparam int TEMP_W         = 11;
    localparam int STATUS_W       = 2;
    localparam int OUT_BYTES_W    = 16;
    localparam int Q_BITS         = 7;   // interpolation quotient stays below 80
    localparam int BIT_W          = $clog2(Q_BITS);
    localparam int DIV_W          = ENTRY_W + Q_BITS;
    localparam int HOT_Q4         = 1280;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [ENTRY_W-1:0]  entry_t;
    typedef logic [DIV_W-1:0]    div_t;
    typedef logic [TEMP_W-1:0]   temp_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_INTERP = 2'd0,
        STATUS_COLD   = 2'd1,
        STATUS_HOT    = 2'd2
    } range_status_t;

    // Falling converter values, one every 5 degrees from 0 to 80 C.
    function automatic entry_t table_value(input idx_t idx);
        entry_t v;
        begin
            case (idx)
                5'd0:    v = 12'd2950;
                5'd1:    v = 12'd2600;
                5'd2:    v = 12'd2330;
                5'd3:    v = 12'd2070;
                5'd4:    v = 12'd1850;
                5'd5:    v = 12'd1650;
                5'd6:    v = 12'd1470;
                5'd7:    v = 12'd1280;
                5'd8:    v = 12'd1120;
                5'd9:    v = 12'd960;
                5'd10:   v = 12'd830;
                5'd11:   v = 12'd710;
                5'd12:   v = 12'd615;
                5'd13:   v = 12'd520;
                5'd14:   v = 12'd440;
                5'd15:   v = 12'd370;
                5'd16:   v = 12'd300;
                default: v = 12'd0;
            endcase
            return v;
        end
    endfunction

endpackage

// ----- sv/ntc_piecewise_linear_temperature.sv -----
// NTC thermistor sample to temperature: serial table search and shift-subtract divide.
// Steps: accept in idle, search the table one entry at a time up to the matched index or
//   the last entry, divide for the interpolated case only, then finish; the finish step waits
//   while the previous result is still unaccepted.
// Throughput: one item at a time; small compare/subtract logic is reused cycle after
//   cycle by the sequencer, s_axis_tready high only while idle. Reset: rst_n async low.
module ntc_piecewise_linear_temperature
    import ntcplt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_BYTES_W-1:0]  s_axis_tdata,   // [11:0] adc_sample, [15:12] zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_BYTES_W-1:0] m_axis_tdata    // [10:0] temperature_q4,
                                                   // [12:11] range_status, [15:13] zero
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t         state_reg, state_next;
    entry_t         sample_reg, sample_next;
    idx_t           idx_reg, idx_next;
    entry_t         span_reg, span_next;
    div_t           rem_reg, rem_next;
    logic [Q_BITS-1:0] quot_reg, quot_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    range_status_t  status_reg, status_next;
    logic           out_valid_reg, out_valid_next;
    temp_t          out_temp_reg, out_temp_next;
    range_status_t  out_status_reg, out_status_next;

    // Shared datapath signals
    entry_t         cur_entry;
    entry_t         prev_entry;
    entry_t         diff;
    div_t           trial;
    logic           trial_fits;
    temp_t          base_q4;
    temp_t          interp_q4;
    temp_t          quot_ext;

    assign cur_entry  = table_value(idx_reg);
    assign prev_entry = table_value(idx_reg - idx_t'(1));
    assign diff       = sample_reg - cur_entry;
    assign trial      = div_t'(span_reg) << bit_reg;
    assign trial_fits = (rem_reg >= trial);

    // 80 * idx as shift and add
    assign base_q4   = temp_t'({idx_reg, 6'b0}) + temp_t'({idx_reg, 4'b0});
    assign quot_ext  = temp_t'(quot_reg);
    assign interp_q4 = (quot_ext > base_q4) ? '0 : base_q4 - quot_ext;

    always_comb
    begin
        state_next      = state_reg;
        sample_next     = sample_reg;
        idx_next        = idx_reg;
        span_next       = span_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        bit_next        = bit_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg;
        out_temp_next   = out_temp_reg;
        out_status_next = out_status_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    sample_next = s_axis_tdata[SAMPLE_BITS-1:0];
                    idx_next    = '0;
                    state_next  = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (cur_entry <= sample_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        status_next = STATUS_COLD;
                        state_next  = ST_FINISH;
                    end
                    else
                    begin
                        status_next = STATUS_INTERP;
                        span_next   = (prev_entry > cur_entry) ? prev_entry - cur_entry : '0;
                        rem_next    = div_t'({diff, 6'b0}) + div_t'({diff, 4'b0});
                        quot_next   = '0;
                        bit_next    = BIT_W'(Q_BITS - 1);
                        state_next  = ST_DIVIDE;
                    end
                end
                else if (idx_reg == idx_t'(SEARCH_LIMIT - 1))
                begin
                    status_next = STATUS_HOT;
                    state_next  = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + idx_t'(1);
                end
            end
            ST_DIVIDE:
            begin
                // Zero span leaves the quotient at zero.
                if (trial_fits && (span_reg != '0))
                begin
                    rem_next           = rem_reg - trial;
                    quot_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    case (status_reg)
                        STATUS_COLD: out_temp_next = '0;
                        STATUS_HOT:  out_temp_next = temp_t'(HOT_Q4);
                        default:     out_temp_next = interp_q4;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            out_temp_reg   <= '0;
            out_status_reg <= STATUS_INTERP;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_temp_reg   <= out_temp_next;
            out_status_reg <= out_status_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        idx_reg        <= idx_next;
        span_reg       <= span_next;
        rem_reg        <= rem_next;
        quot_reg       <= quot_next;
        bit_reg        <= bit_next;
        status_reg     <= status_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_BYTES_W - TEMP_W - STATUS_W){1'b0}},
                            out_status_reg, out_temp_reg};

endmodule

// ----- sim/tb_ntc_piecewise_linear_temperature.sv -----
// Self-checking stream testbench for the NTC sample to temperature converter.
`timescale 1ns / 100ps

module tb_ntc_piecewise_linear_temperature
    import ntcplt_pkg::*;
();

    localparam int STEP_Q4      = 80;       // sixteenths of a degree per 5 C table step
    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;

    // Converter curve, one point every 5 C, falling with temperature.
    localparam logic [ENTRY_W-1:0] NTC_CURVE [0:STORED_ENTRIES-1] = '{
        12'd2950, 12'd2600, 12'd2330, 12'd2070, 12'd1850, 12'd1650,
        12'd1470, 12'd1280, 12'd1120, 12'd960,  12'd830,  12'd710,
        12'd615,  12'd520,  12'd440,  12'd370,  12'd300
    };

    typedef struct packed {
        temp_t         temp_q4;
        range_status_t status;
    } reading_t;

    // Directed stimulus row; known marks rows whose reading is written out here.
    typedef struct packed {
        logic [IN_W-1:0] sample;
        bit              known;
        temp_t           temp_q4;
        range_status_t   status;
    } vector_t;

    localparam int NUM_VECTORS = 20;

    vector_t directed_vectors [0:NUM_VECTORS-1] = '{
        '{12'd0,    1'b1, 11'd1280, STATUS_HOT},     // bottom of converter range
        '{12'd4095, 1'b1, 11'd0,    STATUS_COLD},    // top of converter range
        '{12'd2950, 1'b1, 11'd0,    STATUS_COLD},    // exactly on the cold end
        '{12'd2949, 1'b1, 11'd1,    STATUS_INTERP},  // one below cold end
        '{12'd300,  1'b1, 11'd1280, STATUS_INTERP},  // exactly on the hot end
        '{12'd299,  1'b1, 11'd1280, STATUS_HOT},     // one below hot end
        '{12'd1,    1'b1, 11'd1280, STATUS_HOT},
        '{12'd2600, 1'b1, 11'd80,   STATUS_INTERP},
        '{12'd2330, 1'b1, 11'd160,  STATUS_INTERP},
        '{12'd1280, 1'b1, 11'd560,  STATUS_INTERP},
        '{12'd960,  1'b1, 11'd720,  STATUS_INTERP},
        '{12'd710,  1'b1, 11'd880,  STATUS_INTERP},
        '{12'd520,  1'b1, 11'd1040, STATUS_INTERP},
        '{12'd1279, 1'b0, 11'd0,    STATUS_INTERP},
        '{12'd301,  1'b0, 11'd0,    STATUS_INTERP},
        '{12'd369,  1'b0, 11'd0,    STATUS_INTERP},
        '{12'd2599, 1'b0, 11'd0,    STATUS_INTERP},
        '{12'd2730, 1'b0, 11'd0,    STATUS_INTERP},  // alternating bits
        '{12'd1365, 1'b0, 11'd0,    STATUS_INTERP},  // alternating bits, other phase
        '{12'd2048, 1'b0, 11'd0,    STATUS_INTERP}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_BYTES_W-1:0]  s_axis_tdata = '0;    // [11:0] adc_sample, [15:12] zero
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;         // [10:0] temperature_q4,
                                                  // [12:11] range_status, [15:13] zero

    reading_t pending_readings [$];   // readings owed by the converter, oldest first

    int  mismatches = 0;
    int  cycles = 0;
    int  samples_sent = 0;
    int  seen_interp = 0;
    int  seen_cold = 0;
    int  seen_hot = 0;
    bit  src_idle_on = 1'b0;
    bit  sink_idle_on = 1'b0;
    int  sink_stall_left = 0;

    ntc_piecewise_linear_temperature uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected reading: search for the first curve point not above the sample,
    // then interpolate back toward the previous (colder) point.
    function automatic reading_t convert_sample(input logic [IN_W-1:0] sample);
        reading_t    r;
        int unsigned span;
        int unsigned frac;
        bit          found;
        r.temp_q4 = temp_t'(HOT_Q4);
        r.status  = STATUS_HOT;
        found     = 1'b0;
        for (int i = 0; i < SEARCH_LIMIT; i++)
        begin
            if (!found && NTC_CURVE[i] <= sample)
            begin
                found = 1'b1;
                if (i == 0)
                begin
                    r.temp_q4 = '0;
                    r.status  = STATUS_COLD;
                end
                else
                begin
                    span = (NTC_CURVE[i-1] > NTC_CURVE[i]) ? NTC_CURVE[i-1] - NTC_CURVE[i] : 0;
                    frac = 0;
                    // a flat step would make the quotient zero
                    if (span != 0)
                        frac = (STEP_Q4 * (sample - NTC_CURVE[i])) / span;
                    if (frac > STEP_Q4 * i)
                        frac = STEP_Q4 * i;
                    r.temp_q4 = temp_t'(STEP_Q4 * i - frac);
                    r.status  = STATUS_INTERP;
                end
            end
        end
        return r;
    endfunction

    // Random sample, weighted toward the table so every segment is exercised.
    function automatic logic [IN_W-1:0] pick_sample();
        int mode;
        int s;
        mode = $urandom_range(0, 99);
        if (mode < 65)
            s = $urandom_range(300, 2949);
        else if (mode < 80)
            s = int'(NTC_CURVE[$urandom_range(0, STORED_ENTRIES-1)]) + $urandom_range(0, 4) - 2;
        else if (mode < 90)
            s = $urandom_range(0, 4095);
        else if (mode < 95)
            s = $urandom_range(0, 299);
        else
            s = $urandom_range(2950, 4095);
        return s[IN_W-1:0];
    endfunction

    // Drive a sample and wait for its transfer; called just after the clock rises.
    task automatic send_sample(input logic [IN_W-1:0] sample, input reading_t expected);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_BYTES_W-IN_W){1'b0}}, sample};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_readings.push_back(expected);
        samples_sent++;
    endtask

    // Sender gap now and then, while source idling is on.
    task automatic maybe_idle_source();
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // Receiver: ready drops in bursts while stalling is enabled.
    always @(posedge clk)
    begin
        if (sink_stall_left > 0)
        begin
            m_axis_tready   <= 1'b0;
            sink_stall_left <= sink_stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (sink_idle_on && $urandom_range(0, 5) == 0)
                sink_stall_left <= $urandom_range(1, 10);
        end
    end

    // Result checker: each transfer out is matched with the oldest pending reading.
    always @(posedge clk)
    begin
        reading_t      want;
        temp_t         got_temp;
        range_status_t got_status;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_temp   = m_axis_tdata[TEMP_W-1:0];
            got_status = range_status_t'(m_axis_tdata[TEMP_W +: STATUS_W]);
            case (got_status)
                STATUS_INTERP: seen_interp++;
                STATUS_COLD:   seen_cold++;
                STATUS_HOT:    seen_hot++;
                default:       ;
            endcase
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected result temperature_q4=%0d range_status=%0d",
                         $time, got_temp, got_status);
                mismatches++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got_temp !== want.temp_q4)
                begin
                    $display("%0t: temperature_q4 mismatch: expected %0d, actual %0d",
                             $time, want.temp_q4, got_temp);
                    mismatches++;
                end
                if (got_status !== want.status)
                begin
                    $display("%0t: range_status mismatch: expected %0d, actual %0d",
                             $time, want.status, got_status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d readings still pending",
                     $time, cycles, pending_readings.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        reading_t expected;
        logic [IN_W-1:0] sample;

        // reset held low, then released on a clock edge
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: edges of the table, clamps, alternating bit patterns
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int n = 0; n < NUM_VECTORS; n++)
        begin
            maybe_idle_source();
            if (directed_vectors[n].known)
            begin
                expected.temp_q4 = directed_vectors[n].temp_q4;
                expected.status  = directed_vectors[n].status;
            end
            else
                expected = convert_sample(directed_vectors[n].sample);
            send_sample(directed_vectors[n].sample, expected);
        end

        // random part; idling switched per phase, full speed at the end
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 400)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end
            else if (n == 550)
            begin
                src_idle_on  = 1'b1;
                sink_idle_on = 1'b1;
            end
            else if (n == RANDOM_ITEMS - 300)
            begin
                src_idle_on  = 1'b0;
                sink_idle_on = 1'b0;
            end

            if (n == 700)
            begin
                // hold off until the converter has delivered everything owed
                s_axis_tvalid <= 1'b0;
                while (pending_readings.size() != 0)
                    @(posedge clk);
                @(posedge clk);
            end
            else
                maybe_idle_source();

            sample = pick_sample();
            send_sample(sample, convert_sample(sample));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d samples converted: %0d interpolated, %0d clamped cold, %0d clamped hot",
                 samples_sent, seen_interp, seen_cold, seen_hot);
        $display("table ends, every curve point and its neighbours, random idling both sides");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- ntc_piecewise_linear_temperature.f -----
sv/ntcplt_pkg.sv
sv/ntc_piecewise_linear_temperature.sv
sim/tb_ntc_piecewise_linear_temperature.sv
